/* rtl/ctc_pkg.sv */
// Shared types and constants of the four-channel counter/timer.
package ctc_pkg;

	// Request commands.
	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_ACK   = 2'd3
	} cmd_e;

	// Control word bit positions.
	localparam int CW_INT_EN   = 7;
	localparam int CW_COUNTER  = 6;
	localparam int CW_PRE_256  = 5;
	localparam int CW_TRIGGER  = 3;
	localparam int CW_TC_NEXT  = 2;
	localparam int CW_RESET    = 1;

	localparam logic [7:0] CW_RESET_VAL = 8'h03;
	localparam logic [7:0] CW_CLR_MASK  = 8'h06;
	localparam logic [8:0] TC_MAX       = 9'h100;
	localparam logic [7:0] PRE_LAST_256 = 8'hff;
	localparam logic [7:0] PRE_LAST_16  = 8'h0f;

	// Complete architectural state of the four channels.
	typedef struct packed {
		logic [3:0][7:0] cw;
		logic [3:0][8:0] tc;
		logic [3:0][8:0] dc;
		logic [3:0][7:0] ps;
		logic [4:0]      vb;
		logic [3:0]      pend;
		logic            tog;
	} state_t;

	// One result item.
	typedef struct packed {
		logic [7:0] read_data;
		logic [3:0] irq_pending;
		logic [3:0] zero_count;
	} result_t;

endpackage

/* rtl/ctc_req_if.sv */
// Request channel: command, channel and data byte with valid/ready.
interface ctc_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [1:0] channel;
	logic [7:0] data;

	modport source(output valid, command, channel, data, input ready);
	modport sink(input valid, command, channel, data, output ready);
endinterface

/* rtl/ctc_rsp_if.sv */
// Result channel: read byte, pending interrupts and zero counts with valid/ready.
interface ctc_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic [3:0] irq_pending;
	logic [3:0] zero_count;

	modport source(output valid, read_data, irq_pending, zero_count, input ready);
	modport sink(input valid, read_data, irq_pending, zero_count, output ready);
endinterface

/* rtl/counter_timer_channels.sv */
// A request passes the input register, then the result register, before its result is offered.
// Throughput: one request per cycle when not stalled; all four channels update in one pass.
// Ready follows the result register: a held result only stalls once the input register is full.
// Reset: asynchronous, active low; control words become 0x03, counters, time constants,
// prescalers, vector and pending requests clear, and both registers empty.
// Top level of the four-channel counter/timer.
module counter_timer_channels (
	input  logic       clk,
	input  logic       arst_n,
	ctc_req_if.sink    req,
	ctc_rsp_if.source  rsp
);

	logic             valid_s1;
	ctc_pkg::cmd_e    cmd_s1;
	logic [1:0]       ch_s1;
	logic [7:0]       data_s1;
	ctc_pkg::state_t  state_q;
	ctc_pkg::state_t  state_nxt;
	ctc_pkg::result_t res_nxt;
	ctc_pkg::result_t res_q;
	logic             out_valid_q;
	logic             adv;

	// The input register hands over whenever the result register is free or being emptied.
	assign adv       = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	// Combinational update of the channel state for the registered request.
	ctc_step u_step (
		.st   (state_q),
		.cmd  (cmd_s1),
		.ch   (ch_s1),
		.data (data_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Control and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			state_q       <= '{cw: {4{ctc_pkg::CW_RESET_VAL}}, default: '0};
		end else begin
			if (req.valid && req.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1  <= ctc_pkg::cmd_e'(req.command);
			ch_s1   <= req.channel;
			data_s1 <= req.data;
		end
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.read_data   = res_q.read_data;
	assign rsp.irq_pending = res_q.irq_pending;
	assign rsp.zero_count  = res_q.zero_count;

`ifndef NO_ASSERTIONS
	// Only a tick can report zero counts.
	a_zc_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (cmd_s1 != ctc_pkg::CMD_TICK) |=> (rsp.zero_count == 4'd0))
		else $error("zero count reported for a request that is not a tick");

	// An acknowledge leaves its channel not pending and answers an even byte.
	a_ack_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (cmd_s1 == ctc_pkg::CMD_ACK) |=>
		(!rsp.irq_pending[$past(ch_s1)] && !rsp.read_data[0]))
		else $error("acknowledge did not clear its pending request");

	// Control words only ever hold odd values.
	a_cw_odd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.cw[0][0] && state_q.cw[1][0] && state_q.cw[2][0] && state_q.cw[3][0])
		else $error("control word lost its low bit");

	// The result register only advances when it was free or being taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp.ready |=> $stable(res_q) && out_valid_q)
		else $error("pending result overwritten");
`endif

endmodule

/* rtl/ctc_step.sv */
// Next-state and result logic for one request applied to the channel state.
module ctc_step (
	input  ctc_pkg::state_t  st,
	input  ctc_pkg::cmd_e    cmd,
	input  logic [1:0]       ch,
	input  logic [7:0]       data,
	output ctc_pkg::state_t  nxt,
	output ctc_pkg::result_t res
);

	// A channel runs when not in reset, loaded, and it has a clock source.
	function automatic logic [3:0] run_vec(input logic [3:0][7:0] cw,
			input logic [3:0][8:0] tc);
		logic [3:0] base;
		logic [3:0] run;
		for (int i = 0; i < 4; i++) begin
			base[i] = !cw[i][ctc_pkg::CW_RESET] && (tc[i] != 9'd0);
		end
		run[0] = base[0] && !cw[0][ctc_pkg::CW_COUNTER] && !cw[0][ctc_pkg::CW_TRIGGER];
		run[1] = base[1];
		run[2] = base[2];
		run[3] = base[3] && ((cw[3][ctc_pkg::CW_COUNTER] || cw[3][ctc_pkg::CW_TRIGGER])
			? run[0] : 1'b1);
		return run;
	endfunction

	logic [3:0] run_old;
	logic [3:0] run_new;
	logic [3:0] zc;
	logic [3:0] step;
	logic       upd;
	logic [7:0] last;

	always_comb begin
		nxt     = st;
		res     = '0;
		zc      = '0;
		step    = '0;
		upd     = 1'b0;
		last    = '0;
		run_old = run_vec(st.cw, st.tc);
		run_new = run_old;
		case (cmd)
			ctc_pkg::CMD_WRITE: begin
				// Time constant, changed control word or vector; first two restart.
				if (st.cw[ch][ctc_pkg::CW_TC_NEXT]) begin
					nxt.tc[ch] = (data == 8'd0) ? ctc_pkg::TC_MAX : {1'b0, data};
					nxt.cw[ch] = st.cw[ch] & ~ctc_pkg::CW_CLR_MASK;
					upd = 1'b1;
				end else if (data[0]) begin
					if (st.cw[ch] != data) begin
						nxt.cw[ch] = data;
						upd = 1'b1;
					end
				end else begin
					nxt.vb = data[7:3];
				end
				run_new = run_vec(nxt.cw, nxt.tc);
				for (int c = 0; c < 4; c++) begin
					if (upd && ((2'(c) == ch) || (c == 3 && ch == 2'd0))) begin
						nxt.dc[c] = nxt.tc[c];
						nxt.ps[c] = '0;
						if (nxt.cw[c][ctc_pkg::CW_RESET] ||
								(run_new[c] && !nxt.cw[c][ctc_pkg::CW_INT_EN])) begin
							nxt.pend[c] = 1'b0;
						end
					end
				end
			end
			ctc_pkg::CMD_READ: begin
				res.read_data = run_old[ch] ? st.dc[ch][7:0] : st.tc[ch][7:0];
			end
			ctc_pkg::CMD_TICK: begin
				// Every running channel may advance; channel 3 may chain on channel 0.
				nxt.tog = ~st.tog;
				for (int i = 0; i < 4; i++) begin
					if (run_old[i]) begin
						if (st.cw[i][ctc_pkg::CW_COUNTER]) begin
							step[i] = (i == 3) ? zc[0] : nxt.tog;
						end else begin
							last = st.cw[i][ctc_pkg::CW_PRE_256] ?
								ctc_pkg::PRE_LAST_256 : ctc_pkg::PRE_LAST_16;
							if (st.ps[i] >= last) begin
								nxt.ps[i] = '0;
								step[i]   = 1'b1;
							end else begin
								nxt.ps[i] = st.ps[i] + 8'd1;
							end
						end
						if (step[i]) begin
							if (st.dc[i] <= 9'd1) begin
								nxt.dc[i] = st.tc[i];
								zc[i]     = 1'b1;
								if (st.cw[i][ctc_pkg::CW_INT_EN]) begin
									nxt.pend[i] = 1'b1;
								end
							end else begin
								nxt.dc[i] = st.dc[i] - 9'd1;
							end
						end
					end
				end
			end
			ctc_pkg::CMD_ACK: begin
				res.read_data = {st.vb, ch, 1'b0};
				nxt.pend[ch]  = 1'b0;
			end
			default: begin
			end
		endcase
		res.irq_pending = nxt.pend;
		res.zero_count  = zc;
	end

endmodule
